@@ rtl/core/keyframe_curve_player_unit_defines.svh @@
// Assertion macros used by the checker file kcp_checker.
`ifndef KEYFRAME_CURVE_PLAYER_UNIT_DEFINES_SVH
`define KEYFRAME_CURVE_PLAYER_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define KCP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define KCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/core/kcp_pkg.sv @@
// ----------------------------------------------------------------------------
// kcp_pkg
// Types and constants for the keyframe curve player.
// ----------------------------------------------------------------------------
`default_nettype none
package kcp_pkg;
    localparam int MaxKeys = 16;
    localparam int IdxW = $clog2(MaxKeys);
    localparam int CntW = $clog2(MaxKeys + 1);

    localparam logic [2:0] CMD_TICK = 3'd0;
    localparam logic [2:0] CMD_SET = 3'd1;
    localparam logic [2:0] CMD_DEL = 3'd2;
    localparam logic [2:0] CMD_PLAY = 3'd3;
    localparam logic [2:0] CMD_RESUME = 3'd4;
    localparam logic [2:0] CMD_STOP = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [2:0] REG_LERP = 3'd0;
    localparam logic [2:0] REG_ACC = 3'd1;
    localparam logic [2:0] REG_DEC = 3'd2;
    localparam logic [2:0] REG_SMOOTH = 3'd3;
    localparam logic [2:0] REG_LOOP = 3'd4;
    localparam logic [2:0] REG_LPOINT = 3'd5;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] key_time;
        logic signed [31:0] key_value;
        logic [31:0] time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] curve_value;
        logic               is_playing;
        logic [1:0]         status;
    } t_out_item;

    // Divider request and response between the top level and the divider.
    typedef struct packed {
        logic        start;
        logic [48:0] num;
        logic [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [48:0] quot;
        logic [32:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

@@ rtl/core/kcp_divider.sv @@
// ----------------------------------------------------------------------------
// kcp_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module kcp_divider
    import kcp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  var  t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [48:0] r_quot, n_quot;
    logic [32:0] r_rem, n_rem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [33:0] w_trial;
    logic [33:0] w_sub;

    always_comb begin
        w_trial = {r_rem, r_quot[48]};
        w_sub = w_trial - {1'b0, r_den};
        if (!w_sub[33]) begin
            n_rem = w_sub[32:0];
            n_quot = {r_quot[47:0], 1'b1};
        end else begin
            n_rem = w_trial[32:0];
            n_quot = {r_quot[47:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd49;
                r_quot <= i_req.num;
                r_rem <= '0;
                r_den <= i_req.den;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem = r_rem;
endmodule
`default_nettype wire

@@ rtl/core/keyframe_curve_player_unit.sv @@
// ----------------------------------------------------------------------------
// keyframe_curve_player_unit
// Sorted keyframe table with a playback timer and eased interpolation.
// ----------------------------------------------------------------------------
// Stop and idle commands go straight to the result strobe; set and delete
// scan the table, then shift entries as needed; a tick, play or resume that
// evaluates reads and compares each entry in a table scan and runs the
// bit-serial divide for the normalized time, after a divide for the modulo
// when a loop wrap needs one. One item at a time; busy stays high through the
// result strobe. The receiver cannot stall. Synchronous active-low reset
// clears the count, timer, running flag, held value, status and configuration
// (but sets interpolation on); the table itself is undefined until written.
`default_nettype none
module keyframe_curve_player_unit
    import kcp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  var  t_in_item    i_item,
    output logic             o_strobe,
    output t_out_item        o_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_SET, S_SHIFT_UP, S_SCAN_DEL, S_SHIFT_DN,
        S_EV_LAST, S_EV_WRAP, S_EV_WRAPW, S_EV_SCAN, S_EV_RD1, S_EV_RD2,
        S_EV_DIV, S_EV_DIVW, S_EV_ACC, S_EV_DEC, S_EV_SM1, S_EV_SM2,
        S_EV_LERP, S_EV_FIN, S_DONE
    } t_state;

    // Configuration registers.
    logic        r_lerp, r_acc, r_dec, r_smooth, r_loop;
    logic [31:0] r_lpoint;
    logic        w_wr;
    logic [2:0]  w_reg;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    assign w_reg = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lerp <= 1'b1;
            r_acc <= 1'b0;
            r_dec <= 1'b0;
            r_smooth <= 1'b0;
            r_loop <= 1'b0;
            r_lpoint <= '0;
        end else if (w_wr) begin
            case (w_reg)
                REG_LERP: r_lerp <= pwdata[0];
                REG_ACC: r_acc <= pwdata[0];
                REG_DEC: r_dec <= pwdata[0];
                REG_SMOOTH: r_smooth <= pwdata[0];
                REG_LOOP: r_loop <= pwdata[0];
                REG_LPOINT: r_lpoint <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_LERP: prdata = {31'd0, r_lerp};
            REG_ACC: prdata = {31'd0, r_acc};
            REG_DEC: prdata = {31'd0, r_dec};
            REG_SMOOTH: prdata = {31'd0, r_smooth};
            REG_LOOP: prdata = {31'd0, r_loop};
            REG_LPOINT: prdata = r_lpoint;
            default: prdata = '0;
        endcase
    end

    // The table is a memory with one port: each cycle addresses one entry, reads
    // it and may write it, and read data lands in r_rd_t / r_rd_v the cycle after.
    logic [31:0] m_times [MaxKeys];
    logic [31:0] m_values [MaxKeys];
    logic            w_mwe;
    logic [IdxW-1:0] w_maddr;
    logic [31:0]     w_mwt, w_mwv;
    logic [31:0]     r_rd_t, r_rd_v;

    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            m_times[w_maddr] <= w_mwt;
            m_values[w_maddr] <= w_mwv;
        end
        r_rd_t <= m_times[w_maddr];
        r_rd_v <= m_values[w_maddr];
    end

    // Control and datapath registers.
    t_state          r_state;
    t_in_item        r_in;
    logic [CntW-1:0] r_count;
    logic [31:0]     r_timer;
    logic            r_run;
    logic [31:0]     r_held;
    logic [1:0]      r_status;
    logic [CntW-1:0] r_k;
    logic            r_rdv;
    logic [31:0]     r_last;
    logic [IdxW-1:0] r_i2;
    logic [31:0]     r_t1, r_t2;
    logic signed [31:0] r_v1, r_v2;
    logic [16:0]     r_t;
    logic            r_strobe;
    t_div_req        w_dreq;
    t_div_rsp        w_drsp;

    kcp_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    // Shared helpers.
    logic [32:0] w_tsum;
    logic [31:0] w_tsat;
    logic [IdxW-1:0] w_kidx, w_kidx_m1;
    logic [33:0] w_sq;
    logic [17:0] w_cmp;
    logic [35:0] w_smul;
    logic signed [32:0] w_range;
    logic signed [50:0] w_prod;
    logic signed [34:0] w_v;

    assign w_kidx = r_k[IdxW-1:0];
    assign w_kidx_m1 = w_kidx - IdxW'(1);
    assign w_sq = r_t * r_t;
    assign w_cmp = 18'd196608 - {r_t, 1'b0};
    // Smoothstep second product: the squared time held in r_last times 3-2t.
    assign w_smul = r_last[16:0] * w_cmp;
    assign w_range = {r_v2[31], r_v2} - {r_v1[31], r_v1};
    assign w_prod = w_range * $signed({1'b0, r_t});
    // The arithmetic shift by 16 floors toward minus infinity.
    assign w_v = {{3{r_v1[31]}}, r_v1} + w_prod[50:16];

    always_comb begin
        w_mwe = 1'b0;
        w_maddr = w_kidx;
        w_mwt = r_in.key_time;
        w_mwv = r_in.key_value;
        w_dreq = '0;
        w_tsum = '0;
        w_tsat = '0;
        case (r_state)
            S_SHIFT_UP: begin
                if (r_rdv) begin
                    w_mwe = 1'b1;
                    w_mwt = r_rd_t;
                    w_mwv = r_rd_v;
                end else if (r_k == CntW'(r_in.time_step)) begin
                    // The gap has reached the insert position: write the key.
                    w_mwe = 1'b1;
                end else begin
                    w_maddr = w_kidx_m1;
                end
            end
            S_SHIFT_DN: begin
                if (r_rdv) begin
                    w_mwe = 1'b1;
                    w_mwt = r_rd_t;
                    w_mwv = r_rd_v;
                    w_maddr = w_kidx_m1;
                end
            end
            S_EV_LAST: w_maddr = IdxW'(r_count - CntW'(1));
            S_EV_WRAP: begin
                w_dreq.start = 1'b1;
                w_dreq.num = {17'd0, r_timer};
                w_dreq.den = {1'b0, r_last};
            end
            S_EV_WRAPW: begin
                w_tsum = {1'b0, w_drsp.rem[31:0]} + {1'b0, r_lpoint};
                w_tsat = w_tsum[32] ? 32'hFFFF_FFFF : w_tsum[31:0];
            end
            S_EV_RD1: w_maddr = r_i2;
            S_EV_RD2: w_maddr = (r_i2 == '0) ? '0 : r_i2 - IdxW'(1);
            S_EV_DIV: begin
                // The earlier key's time arrives from the table this cycle.
                w_dreq.start = 1'b1;
                w_dreq.num = {1'b0, (r_timer >= r_rd_t) ? r_timer - r_rd_t : 32'd0, 16'd0};
                w_dreq.den = {1'b0, r_t2 - r_rd_t};
            end
            default: ;
        endcase
        if (r_state == S_IDLE && start && i_item.cmd == CMD_TICK) begin
            w_tsum = {1'b0, r_timer} + {1'b0, i_item.time_step};
            w_tsat = w_tsum[32] ? 32'hFFFF_FFFF : w_tsum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_timer <= '0;
            r_run <= 1'b0;
            r_held <= '0;
            r_strobe <= 1'b0;
            r_status <= ST_OK;
            r_rdv <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    // Busy is still high in the strobe cycle.
                    if (start && !r_strobe) begin
                        r_in <= i_item;
                        r_status <= ST_OK;
                        r_k <= '0;
                        r_rdv <= 1'b0;
                        r_state <= S_DONE;
                        case (i_item.cmd)
                            CMD_TICK: begin
                                if (r_run) begin
                                    if (r_count == '0) begin
                                        r_run <= 1'b0;
                                        r_status <= ST_EMPTY;
                                    end else begin
                                        r_timer <= w_tsat;
                                        r_state <= S_EV_LAST;
                                    end
                                end
                            end
                            CMD_SET: r_state <= S_SCAN_SET;
                            CMD_DEL: r_state <= S_SCAN_DEL;
                            CMD_PLAY, CMD_RESUME: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    if (i_item.cmd == CMD_PLAY) r_timer <= '0;
                                    r_run <= 1'b1;
                                    r_state <= S_EV_LAST;
                                end
                            end
                            CMD_STOP: r_run <= 1'b0;
                            default: ;
                        endcase
                    end
                end
                // Read entry k, compare the cycle after.
                S_SCAN_SET: begin
                    r_rdv <= 1'b0;
                    if (!r_rdv) begin
                        if (r_k == r_count) begin
                            if (r_count == CntW'(MaxKeys)) begin
                                r_status <= ST_FULL;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SHIFT_UP;
                                r_in.time_step <= 32'(r_count);
                                r_k <= r_count;
                            end
                        end else begin
                            r_rdv <= 1'b1;
                        end
                    end else if (r_rd_t == r_in.key_time) begin
                        r_status <= ST_OK;
                        r_state <= S_SHIFT_UP;
                        r_in.time_step <= 32'(r_k);
                        r_count <= r_count - CntW'(1);
                    end else if (r_rd_t > r_in.key_time) begin
                        if (r_count == CntW'(MaxKeys)) begin
                            r_status <= ST_FULL;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SHIFT_UP;
                            r_rdv <= 1'b0;
                            r_in.time_step <= 32'(r_k);
                            r_k <= r_count;
                        end
                    end else begin
                        r_k <= r_k + CntW'(1);
                    end
                end
                // Shift entries up from the end to the insert position, held
                // in time_step; an overwrite arrives with k at the hit.
                S_SHIFT_UP: begin
                    if (!r_rdv && r_k == CntW'(r_in.time_step)) begin
                        r_count <= r_count + CntW'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_rdv <= !r_rdv;
                        if (r_rdv) r_k <= r_k - CntW'(1);
                    end
                end
                S_SCAN_DEL: begin
                    r_rdv <= 1'b0;
                    if (!r_rdv) begin
                        if (r_k == r_count) begin
                            r_status <= ST_MISS;
                            r_state <= S_DONE;
                        end else begin
                            r_rdv <= 1'b1;
                        end
                    end else if (r_rd_t == r_in.key_time) begin
                        r_k <= r_k + CntW'(1);
                        r_state <= S_SHIFT_DN;
                    end else begin
                        r_k <= r_k + CntW'(1);
                    end
                end
                S_SHIFT_DN: begin
                    if (!r_rdv) begin
                        if (r_k == r_count) begin
                            r_count <= r_count - CntW'(1);
                            r_state <= S_DONE;
                        end else begin
                            r_rdv <= 1'b1;
                        end
                    end else begin
                        r_rdv <= 1'b0;
                        r_k <= r_k + CntW'(1);
                    end
                end
                S_EV_LAST: begin
                    r_rdv <= !r_rdv;
                    if (r_rdv) begin
                        r_last <= r_rd_t;
                        r_k <= '0;
                        r_rdv <= 1'b0;
                        r_i2 <= IdxW'(r_count - CntW'(1));
                        r_state <= S_EV_SCAN;
                        if (r_rd_t <= r_timer) begin
                            if (!r_loop) r_timer <= r_rd_t;
                            else if (r_rd_t == '0) r_timer <= r_lpoint;
                            else r_state <= S_EV_WRAP;
                        end
                    end
                end
                S_EV_WRAP: r_state <= S_EV_WRAPW;
                S_EV_WRAPW: begin
                    if (w_drsp.done) begin
                        r_timer <= w_tsat;
                        r_state <= S_EV_SCAN;
                    end
                end
                S_EV_SCAN: begin
                    r_rdv <= 1'b0;
                    if (!r_rdv) begin
                        if (r_k == r_count) r_state <= S_EV_RD1;
                        else r_rdv <= 1'b1;
                    end else if (r_rd_t > r_timer) begin
                        r_i2 <= w_kidx;
                        r_state <= S_EV_RD1;
                    end else begin
                        r_k <= r_k + CntW'(1);
                    end
                end
                S_EV_RD1: r_state <= S_EV_RD2;
                S_EV_RD2: begin
                    r_t2 <= r_rd_t;
                    r_v2 <= r_rd_v;
                    r_state <= S_EV_DIV;
                end
                S_EV_DIV: begin
                    r_t1 <= r_rd_t;
                    r_v1 <= r_rd_v;
                    r_held <= r_v2;
                    if (r_rd_t == r_t2) r_state <= S_EV_FIN;
                    else r_state <= S_EV_DIVW;
                end
                S_EV_DIVW: begin
                    if (w_drsp.done) begin
                        r_t <= (w_drsp.quot > 49'd65536) ? 17'd65536 : w_drsp.quot[16:0];
                        r_state <= S_EV_ACC;
                    end
                end
                S_EV_ACC: begin
                    if (r_acc) r_t <= w_sq[32:16];
                    r_state <= S_EV_DEC;
                end
                // 1-(1-t)^2 reduces exactly to 2t - floor(t*t / 65536).
                S_EV_DEC: begin
                    if (r_dec) r_t <= 17'({r_t, 1'b0} - {1'b0, w_sq[32:16]});
                    r_state <= S_EV_SM1;
                end
                S_EV_SM1: begin
                    r_state <= S_EV_LERP;
                    if (r_smooth) begin
                        r_last <= {15'd0, w_sq[32:16]};
                        r_state <= S_EV_SM2;
                    end
                end
                S_EV_SM2: begin
                    r_t <= w_smul[32:16];
                    r_state <= S_EV_LERP;
                end
                S_EV_LERP: begin
                    if (!r_lerp) r_held <= r_v1;
                    else if (w_v > 35'sd2147483647) r_held <= 32'h7FFF_FFFF;
                    else if (w_v < -35'sd2147483648) r_held <= 32'h8000_0000;
                    else r_held <= w_v[31:0];
                    r_state <= S_EV_FIN;
                end
                S_EV_FIN: begin
                    if (r_t2 == r_timer && !r_loop) r_run <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_strobe <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE) || r_strobe;
    assign o_strobe = r_strobe;
    assign o_item.curve_value = r_held;
    assign o_item.is_playing = r_run;
    assign o_item.status = r_status;
endmodule
`default_nettype wire

@@ rtl/core/kcp_checker.sv @@
// ----------------------------------------------------------------------------
// kcp_checker
// Port-level checks on the command handshake and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyframe_curve_player_unit_defines.svh"
module kcp_checker
    import kcp_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      o_strobe,
    input var  t_out_item o_item
);
    `KCP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy low after accept")
    `KCP_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, o_strobe, !o_strobe, "strobe held")
    `KCP_ASSERT_IMPL(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy, "strobe while idle")
    `KCP_ASSERT_IMPL(a_result_known, i_clk, i_rst_n, o_strobe, !$isunknown(o_item), "result unknown")
endmodule

bind keyframe_curve_player_unit kcp_checker u_kcp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_item  (o_item)
);
`default_nettype wire

@@ tb/sv/keyframe_curve_player_unit_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_curve_player_unit_checker
// Keeps its own keyframe table and playback state, works out the expected
// result of every accepted command and compares it with the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module keyframe_curve_player_unit_checker
    import kcp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_busy,
    input  var  t_in_item   i_item,
    input  wire logic       i_strobe,
    input  var  t_out_item  i_result,
    input  wire logic       i_psel,
    input  wire logic       i_penable,
    input  wire logic       i_pwrite,
    input  wire logic       i_pready,
    input  wire logic [4:0] i_paddr,
    input  wire logic [31:0] i_pwdata,
    output int              o_fail_count,
    output int              o_pending
);
    logic [31:0]        key_times [MaxKeys];
    logic signed [31:0] key_values [MaxKeys];
    int unsigned        key_count;
    logic [31:0]        timer;
    logic               playing;
    logic signed [31:0] curve;
    logic               lerp_on, acc_on, dec_on, smooth_on, loop_on;
    logic [31:0]        loop_at;
    t_out_item          expected_results [$];

    assign o_pending = expected_results.size();

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Places the timer on the curve and refreshes the held value.
    task automatic place_timer();
        logic [31:0] last_t;
        int          hi, lo;
        logic [63:0] span, off, t, c;
        logic signed [63:0] range, v;
        last_t = key_times[key_count-1];
        hi = key_count - 1;
        if (last_t <= timer) begin
            if (!loop_on) timer = last_t;
            else if (last_t == 0) timer = loop_at;
            else timer = add_sat(timer % last_t, loop_at);
        end
        for (int k = 0; k < key_count; k++) begin
            if (key_times[k] > timer) begin
                hi = k;
                break;
            end
        end
        lo = (hi == 0) ? 0 : hi - 1;
        curve = key_values[hi];
        if (key_times[hi] != key_times[lo]) begin
            span = 64'(key_times[hi]) - 64'(key_times[lo]);
            off = (timer >= key_times[lo]) ? 64'(timer) - 64'(key_times[lo]) : 64'd0;
            t = (off << 16) / span;
            if (t > 64'd65536) t = 64'd65536;
            if (acc_on) t = (t * t) >> 16;
            if (dec_on) begin
                c = 64'd65536 - t;
                t = 64'd65536 - ((c * c) >> 16);
            end
            if (smooth_on) t = (((t * t) >> 16) * (64'd196608 - 2 * t)) >> 16;
            if (lerp_on) begin
                range = 64'(key_values[hi]) - 64'(key_values[lo]);
                // Arithmetic shift floors toward minus infinity.
                v = 64'(key_values[lo]) + ((range * $signed(t)) >>> 16);
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                curve = v[31:0];
            end else begin
                curve = key_values[lo];
            end
        end
        if (key_times[hi] == timer && !loop_on) playing = 1'b0;
    endtask

    task automatic predict_result(t_in_item it);
        logic [1:0] st;
        int         pos;
        bit         done;
        t_out_item  r;
        st = ST_OK;
        done = 0;
        case (it.cmd)
            CMD_TICK: begin
                if (playing) begin
                    if (key_count == 0) begin
                        playing = 1'b0;
                        st = ST_EMPTY;
                    end else begin
                        timer = add_sat(timer, it.time_step);
                        place_timer();
                    end
                end
            end
            CMD_SET: begin
                pos = key_count;
                for (int k = 0; k < key_count; k++) begin
                    if (key_times[k] == it.key_time) begin
                        key_values[k] = it.key_value;
                        done = 1;
                        break;
                    end
                    if (key_times[k] > it.key_time) begin
                        pos = k;
                        break;
                    end
                end
                if (!done) begin
                    if (key_count >= MaxKeys) st = ST_FULL;
                    else begin
                        for (int k = key_count; k > pos; k--) begin
                            key_times[k] = key_times[k-1];
                            key_values[k] = key_values[k-1];
                        end
                        key_times[pos] = it.key_time;
                        key_values[pos] = it.key_value;
                        key_count++;
                    end
                end
            end
            CMD_DEL: begin
                st = ST_MISS;
                for (int k = 0; k < key_count; k++) begin
                    if (key_times[k] == it.key_time) begin
                        for (int j = k; j + 1 < key_count; j++) begin
                            key_times[j] = key_times[j+1];
                            key_values[j] = key_values[j+1];
                        end
                        key_count--;
                        st = ST_OK;
                        break;
                    end
                end
            end
            CMD_PLAY, CMD_RESUME: begin
                if (key_count == 0) st = ST_EMPTY;
                else begin
                    if (it.cmd == CMD_PLAY) timer = '0;
                    playing = 1'b1;
                    place_timer();
                end
            end
            CMD_STOP: playing = 1'b0;
            default: ;
        endcase
        r.curve_value = curve;
        r.is_playing = playing;
        r.status = st;
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            key_count = 0;
            timer = '0;
            playing = 1'b0;
            curve = '0;
            lerp_on = 1'b1;
            {acc_on, dec_on, smooth_on, loop_on} = '0;
            loop_at = '0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_result);
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (e.curve_value !== i_result.curve_value)
                        $display("%0t: curve_value expected %0d actual %0d", $time,
                                 e.curve_value, i_result.curve_value);
                    if (e.is_playing !== i_result.is_playing)
                        $display("%0t: is_playing expected %b actual %b", $time,
                                 e.is_playing, i_result.is_playing);
                    if (e.status !== i_result.status)
                        $display("%0t: status expected %0d actual %0d", $time,
                                 e.status, i_result.status);
                    if (e !== i_result) o_fail_count++;
                end
            end
            if (i_start && !i_busy) predict_result(i_item);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_LERP:   lerp_on = i_pwdata[0];
                    REG_ACC:    acc_on = i_pwdata[0];
                    REG_DEC:    dec_on = i_pwdata[0];
                    REG_SMOOTH: smooth_on = i_pwdata[0];
                    REG_LOOP:   loop_on = i_pwdata[0];
                    REG_LPOINT: loop_at = i_pwdata;
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

@@ tb/sv/keyframe_curve_player_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_curve_player_unit_tb
// Drives keyframe edits, playback commands and register settings into the
// curve player; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none
module keyframe_curve_player_unit_tb;
    import kcp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        o_strobe;
    t_out_item   o_item;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    // Times of recently set keyframes (the last 24); half of the random edits reuse
    // them so that overwrites, deletes that hit, and a full table all happen often.
    logic [31:0] used_times [$];

    keyframe_curve_player_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_item(o_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    keyframe_curve_player_unit_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_item(i_item), .i_strobe(o_strobe), .i_result(o_item),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard limit on run time: far above the slowest legal run of all items.
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // Mostly short gaps between items, now and then a long one.
    task automatic idle_gap();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n = 0;
            9: n = $urandom_range(20, 120);
            default: n = $urandom_range(1, 4);
        endcase
        repeat (n) @(negedge i_clk);
    endtask

    // Issues one command and holds start until the block takes it.
    task automatic send_item(logic [2:0] cmd, logic [31:0] kt, logic [31:0] kv,
                             logic [31:0] step);
        i_item.cmd = cmd;
        i_item.key_time = kt;
        i_item.key_value = kv;
        i_item.time_step = step;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        start = 1'b0;
        i_item = t_in_item'($urandom());
        idle_gap();
    endtask

    // Waits until every result is back, then lets the block settle.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 5))
            0, 1, 2: return (used_times.size() != 0) ?
                used_times[$urandom_range(0, used_times.size() - 1)] : 32'd0;
            3: return $urandom();
            default: return $urandom_range(0, 16) << 16;
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            default: return $urandom_range(0, 3 << 16);
        endcase
    endfunction

    task automatic random_item();
        logic [31:0] kt;
        int          r;
        r = $urandom_range(0, 99);
        kt = pick_time();
        if (r < 45) send_item(CMD_TICK, $urandom(), $urandom(), pick_step());
        else if (r < 65) begin
            send_item(CMD_SET, kt, $urandom(), $urandom());
            used_times.push_back(kt);
            if (used_times.size() > 24) used_times.pop_front();
        end else if (r < 75) send_item(CMD_DEL, kt, $urandom(), $urandom());
        else if (r < 84) send_item(CMD_PLAY, $urandom(), $urandom(), $urandom());
        else if (r < 92) send_item(CMD_RESUME, $urandom(), $urandom(), $urandom());
        else if (r < 98) send_item(CMD_STOP, $urandom(), $urandom(), $urandom());
        else send_item(3'($urandom_range(6, 7)), $urandom(), $urandom(), $urandom());
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty table cases, miss, extremes, full table, clamping.
        send_item(CMD_PLAY, 0, 0, 0);
        send_item(CMD_RESUME, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 32'hFFFF_FFFF);
        send_item(CMD_DEL, 32'h0001_0000, 0, 0);
        send_item(3'd6, 0, 0, 0);
        send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_SET, 0, 32'h8000_0000, 0);
        send_item(CMD_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        send_item(CMD_PLAY, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 32'h8000_0000);
        send_item(CMD_TICK, 0, 0, 32'hFFFF_FFFF);
        send_item(CMD_SET, 0, 32'h7FFF_FFFF, 0);
        for (int k = 1; k <= 15; k++)
            send_item(CMD_SET, k << 16, $urandom(), 0);
        send_item(CMD_SET, 32'h0080_0000, 1, 0);
        send_item(CMD_RESUME, 0, 0, 0);
        send_item(CMD_STOP, 0, 0, 0);
        send_item(CMD_DEL, 32'hFFFF_FFFF, 0, 0);
        drain();

        // Random phases, each under a fresh setting of all registers.
        for (int ph = 0; ph < 10; ph++) begin
            logic [31:0] lp;
            case (ph)
                0: lp = 32'd0;
                1: lp = 32'hFFFF_FFFF;
                2: lp = 32'h0020_0000;
                default: lp = $urandom_range(0, 20 << 16);
            endcase
            write_reg(REG_LERP, (ph == 1) ? 32'd0 : (ph == 0) ? 32'd1 : $urandom());
            write_reg(REG_ACC, (ph == 1) ? 32'd1 : (ph == 0) ? 32'd0 : $urandom());
            write_reg(REG_DEC, (ph == 1) ? 32'd1 : (ph == 0) ? 32'd0 : $urandom());
            write_reg(REG_SMOOTH, (ph == 1) ? 32'd1 : (ph == 0) ? 32'd0 : $urandom());
            write_reg(REG_LOOP, (ph == 0) ? 32'd0 : (ph == 1) ? 32'd1 : $urandom());
            write_reg(REG_LPOINT, lp);
            // A zero-time key gives the zero end time wrap when alone.
            if (ph == 2) begin
                send_item(CMD_SET, 0, 32'h0005_0000, 0);
                while (used_times.size() != 0) void'(used_times.pop_front());
            end
            repeat (140) random_item();
            drain();
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/kcp_pkg.sv
rtl/core/kcp_divider.sv
rtl/core/keyframe_curve_player_unit.sv
rtl/core/kcp_checker.sv
tb/sv/keyframe_curve_player_unit_checker.sv
tb/sv/keyframe_curve_player_unit_tb.sv
